### src/bif_pkg.sv
// ----------------------------------------------------------------------------
// bif_pkg: shared types and constants of the brace indent formatter
// payload structs, character codes and the link between sequencer and buffer
// ----------------------------------------------------------------------------
package bif_pkg;

  // depth saturation limit and storage widths
  localparam int MAX_DEPTH = 15;
  localparam int DEPTH_W   = 5;
  localparam int IND_W     = 6;

  // character codes
  localparam logic [7:0] CH_NL   = 8'h0a;
  localparam logic [7:0] CH_SP   = 8'h20;
  localparam logic [7:0] CH_SEMI = 8'h3b;
  localparam logic [7:0] CH_OPEN = 8'h7b;
  localparam logic [7:0] CH_CLOS = 8'h7d;

  typedef struct packed {
    logic [7:0] in_byte;
    logic       in_last;
  } in_item_t;

  typedef struct packed {
    logic [7:0] out_byte;
    logic       has_byte;
    logic       run_last;
    logic       text_end;
  } out_item_t;

  // sequencer to output buffer
  typedef struct packed {
    logic       push;
    logic [7:0] push_byte;
    logic       flush;
    logic       flush_end;
  } obuf_req_t;

  // output buffer to sequencer
  typedef struct packed {
    logic push_ok;
    logic flush_ok;
  } obuf_stat_t;

endpackage

### src/bif_obuf.sv
// ----------------------------------------------------------------------------
// bif_obuf: look-ahead byte and output register
// holds one byte back so the last byte of an item can carry run_last
// ----------------------------------------------------------------------------
module bif_obuf (
  input  logic                   clk,
  input  logic                   rst_n,
  input  bif_pkg::obuf_req_t     req,
  output bif_pkg::obuf_stat_t    stat,
  output logic                   out_valid,
  input  logic                   out_ready,
  output bif_pkg::out_item_t     out_data
);
  import bif_pkg::*;

  logic       pend_valid_r, pend_valid_nxt;
  logic [7:0] pend_byte_r, pend_byte_nxt;
  logic       out_valid_r, out_valid_nxt;
  out_item_t  out_data_r, out_data_nxt;
  logic       out_free;

  assign out_free      = !out_valid_r || out_ready;
  assign stat.push_ok  = !pend_valid_r || out_free;
  assign stat.flush_ok = !(pend_valid_r || req.flush_end) || out_free;

  always_comb begin
    pend_valid_nxt = pend_valid_r;
    pend_byte_nxt  = pend_byte_r;
    out_valid_nxt  = out_valid_r;
    out_data_nxt   = out_data_r;
    if (out_valid_r && out_ready) begin
      out_valid_nxt = 1'b0;
    end
    if (req.push && stat.push_ok) begin
      // an older byte is now known not to end its item
      if (pend_valid_r) begin
        out_valid_nxt = 1'b1;
        out_data_nxt  = '{out_byte: pend_byte_r, has_byte: 1'b1,
                          run_last: 1'b0, text_end: 1'b0};
      end
      pend_valid_nxt = 1'b1;
      pend_byte_nxt  = req.push_byte;
    end else if (req.flush && stat.flush_ok) begin
      if (pend_valid_r) begin
        out_valid_nxt  = 1'b1;
        out_data_nxt   = '{out_byte: pend_byte_r, has_byte: 1'b1,
                           run_last: 1'b1, text_end: req.flush_end};
        pend_valid_nxt = 1'b0;
      end else if (req.flush_end) begin
        // bare end marker
        out_valid_nxt = 1'b1;
        out_data_nxt  = '{out_byte: 8'h00, has_byte: 1'b0,
                          run_last: 1'b1, text_end: 1'b1};
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pend_valid_r <= 1'b0;
      out_valid_r  <= 1'b0;
    end else begin
      pend_valid_r <= pend_valid_nxt;
      out_valid_r  <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    pend_byte_r <= pend_byte_nxt;
    out_data_r  <= out_data_nxt;
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule

### src/brace_indent_text_formatter_core.sv
// ----------------------------------------------------------------------------
// brace_indent_text_formatter_core: byte stream reformatter with brace indent
// path: an accepted byte passes through the blank, indent and hold states of the sequencer
//   into the look-ahead byte; the look-ahead byte holds the item's last result until its end
// flow: a new input byte is taken only in idle, after the previous one is flushed; indent
//   spaces, released newlines, inserted breaks, implied newlines and collapsed spaces add
//   work; output stalls hold the sequencer; the shared emitter sends every result
// reset: rst_n synchronous active low; line state returns to start of text
// ----------------------------------------------------------------------------
module brace_indent_text_formatter_core (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  input  bif_pkg::in_item_t  in_data,
  output logic               out_valid,
  input  logic               out_ready,
  output bif_pkg::out_item_t out_data
);
  import bif_pkg::*;

  // sequencer states
  typedef enum logic [4:0] {
    ST_IDLE   = 5'b00001,
    ST_BLANK  = 5'b00010,
    ST_INDENT = 5'b00100,
    ST_HOLD   = 5'b01000,
    ST_FLUSH  = 5'b10000
  } state_t;

  // position inside one input: inserted break, the character, implied newline
  typedef enum logic [1:0] {
    SLOT_BRK  = 2'd0,
    SLOT_CHR  = 2'd1,
    SLOT_END  = 2'd2,
    SLOT_DONE = 2'd3
  } slot_t;

  localparam logic signed [DEPTH_W-1:0] DMAX = DEPTH_W'(MAX_DEPTH);
  localparam logic signed [DEPTH_W-1:0] DMIN = -DMAX;

  function automatic logic is_break(input logic [7:0] c);
    return (c == CH_SEMI) || (c == CH_OPEN) || (c == CH_CLOS);
  endfunction

  state_t                    state_r, state_nxt;
  slot_t                     slot_r, slot_nxt;
  logic                      sub_r, sub_nxt;
  logic [7:0]                byte_r, byte_nxt;
  logic                      last_r, last_nxt;
  logic [IND_W-1:0]          cnt_r, cnt_nxt;
  logic [7:0]                hold_r, hold_nxt;

  // line state
  logic                      brk_owed_r, brk_owed_nxt;
  logic                      clean_r, clean_nxt;
  logic                      sp_owed_r, sp_owed_nxt;
  logic                      prev_nl_r, prev_nl_nxt;
  logic                      at_start_r, at_start_nxt;
  logic signed [DEPTH_W-1:0] depth_r, depth_nxt;
  logic                      nl_owed_r, nl_owed_nxt;

  // dispatch scratch
  logic [7:0]                slot_chr;
  logic                      slot_vis;
  logic                      tail_nl;
  slot_t                     slot_adv;
  logic                      blk_has;
  logic [7:0]                blk_chr;
  logic                      do_ind;
  logic signed [DEPTH_W-1:0] depth_a;
  logic                      ind_lead;
  logic [IND_W-1:0]          ind_cnt;
  logic [7:0]                hold_chr;
  logic                      hold_done;

  obuf_req_t                 obuf_req;
  obuf_stat_t                obuf_stat;

  assign in_ready = (state_r == ST_IDLE);

  // current character fed to the space stage
  assign slot_chr = (slot_r == SLOT_CHR) ? byte_r : CH_NL;
  assign slot_vis = (slot_chr != CH_NL) && (slot_chr != CH_SP);
  // missing final newline is implied after the last character
  assign tail_nl  = last_r && (byte_r != CH_NL);

  always_comb begin
    unique case (slot_r)
      SLOT_BRK: slot_adv = SLOT_CHR;
      SLOT_CHR: slot_adv = tail_nl ? SLOT_END : SLOT_DONE;
      default:  slot_adv = SLOT_DONE;
    endcase
  end

  always_comb begin
    state_nxt    = state_r;
    slot_nxt     = slot_r;
    sub_nxt      = sub_r;
    byte_nxt     = byte_r;
    last_nxt     = last_r;
    cnt_nxt      = cnt_r;
    hold_nxt     = hold_r;
    brk_owed_nxt = brk_owed_r;
    clean_nxt    = clean_r;
    sp_owed_nxt  = sp_owed_r;
    prev_nl_nxt  = prev_nl_r;
    at_start_nxt = at_start_r;
    depth_nxt    = depth_r;
    nl_owed_nxt  = nl_owed_r;
    blk_has      = 1'b0;
    blk_chr      = slot_chr;
    do_ind       = 1'b0;
    depth_a      = depth_r;
    ind_lead     = 1'b0;
    ind_cnt      = '0;
    hold_chr     = hold_r;
    hold_done    = 1'b0;
    obuf_req     = '0;

    unique case (state_r)
      ST_IDLE: begin
        if (in_valid) begin
          byte_nxt     = in_data.in_byte;
          last_nxt     = in_data.in_last;
          // an owed break becomes a newline unless one arrives anyway
          slot_nxt     = (brk_owed_r && (in_data.in_byte != CH_NL)) ? SLOT_BRK
                                                                      : SLOT_CHR;
          sub_nxt      = 1'b0;
          brk_owed_nxt = is_break(in_data.in_byte);
          state_nxt    = ST_BLANK;
        end
      end

      ST_BLANK: begin
        if (slot_r == SLOT_DONE) begin
          state_nxt = ST_FLUSH;
        end else begin
          if (!sub_r && slot_vis && sp_owed_r) begin
            // collapsed space run goes out before the visible character
            blk_has     = 1'b1;
            blk_chr     = CH_SP;
            sp_owed_nxt = 1'b0;
            sub_nxt     = 1'b1;
          end else begin
            sub_nxt  = 1'b0;
            slot_nxt = slot_adv;
            if (slot_chr == CH_NL) begin
              sp_owed_nxt = 1'b0;
              clean_nxt   = 1'b1;
              blk_has     = 1'b1;
            end else if (slot_chr == CH_SP) begin
              if (!clean_r) begin
                sp_owed_nxt = 1'b1;
              end
            end else begin
              blk_has   = 1'b1;
              clean_nxt = 1'b0;
            end
          end

          // blank line removal: a second newline in a row is dropped
          do_ind = blk_has && !((blk_chr == CH_NL) && prev_nl_r);
          if (blk_has) begin
            prev_nl_nxt = (blk_chr == CH_NL);
          end

          if (do_ind) begin
            // closing brace at line start lowers the level before the indent
            if ((blk_chr == CH_CLOS) && at_start_r && (depth_r > DMIN)) begin
              depth_a = depth_r - DEPTH_W'(1);
            end
            ind_lead = at_start_r && (blk_chr != CH_NL);
            if (ind_lead && (depth_a > 0)) begin
              ind_cnt = {depth_a[DEPTH_W-2:0], 2'b00};
            end
            if (ind_lead) begin
              at_start_nxt = 1'b0;
            end
            if (blk_chr == CH_NL) begin
              at_start_nxt = 1'b1;
            end
            depth_nxt = depth_a;
            if ((blk_chr == CH_OPEN) && (depth_a < DMAX)) begin
              depth_nxt = depth_a + DEPTH_W'(1);
            end
            cnt_nxt   = ind_cnt;
            hold_nxt  = blk_chr;
            state_nxt = (ind_cnt != '0) ? ST_INDENT : ST_HOLD;
          end else if (slot_nxt == SLOT_DONE) begin
            state_nxt = ST_FLUSH;
          end
        end
      end

      ST_INDENT, ST_HOLD: begin
        // shared emitter: a newline is held until a further character follows
        hold_chr = (state_r == ST_INDENT) ? CH_SP : hold_r;
        if (hold_chr == CH_NL) begin
          nl_owed_nxt = 1'b1;
          hold_done   = 1'b1;
        end else begin
          obuf_req.push      = 1'b1;
          obuf_req.push_byte = nl_owed_r ? CH_NL : hold_chr;
          if (obuf_stat.push_ok) begin
            if (nl_owed_r) begin
              nl_owed_nxt = 1'b0;
            end else begin
              hold_done = 1'b1;
            end
          end
        end
        if (hold_done) begin
          if (state_r == ST_INDENT) begin
            cnt_nxt = cnt_r - IND_W'(1);
            if (cnt_r == IND_W'(1)) begin
              state_nxt = ST_HOLD;
            end
          end else begin
            state_nxt = (slot_r == SLOT_DONE) ? ST_FLUSH : ST_BLANK;
          end
        end
      end

      ST_FLUSH: begin
        // mark the last result of the item, or send a bare end marker
        obuf_req.flush     = 1'b1;
        obuf_req.flush_end = last_r;
        if (obuf_stat.flush_ok) begin
          state_nxt = ST_IDLE;
          if (last_r) begin
            brk_owed_nxt = 1'b0;
            clean_nxt    = 1'b1;
            sp_owed_nxt  = 1'b0;
            prev_nl_nxt  = 1'b0;
            at_start_nxt = 1'b1;
            depth_nxt    = '0;
            nl_owed_nxt  = 1'b0;
          end
        end
      end

      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r    <= ST_IDLE;
      slot_r     <= SLOT_DONE;
      sub_r      <= 1'b0;
      brk_owed_r <= 1'b0;
      clean_r    <= 1'b1;
      sp_owed_r  <= 1'b0;
      prev_nl_r  <= 1'b0;
      at_start_r <= 1'b1;
      depth_r    <= '0;
      nl_owed_r  <= 1'b0;
      cnt_r      <= '0;
    end else begin
      state_r    <= state_nxt;
      slot_r     <= slot_nxt;
      sub_r      <= sub_nxt;
      brk_owed_r <= brk_owed_nxt;
      clean_r    <= clean_nxt;
      sp_owed_r  <= sp_owed_nxt;
      prev_nl_r  <= prev_nl_nxt;
      at_start_r <= at_start_nxt;
      depth_r    <= depth_nxt;
      nl_owed_r  <= nl_owed_nxt;
      cnt_r      <= cnt_nxt;
    end
  end

  // item payload
  always_ff @(posedge clk) begin
    byte_r <= byte_nxt;
    last_r <= last_nxt;
    hold_r <= hold_nxt;
  end

  bif_obuf u_obuf (
    .clk       (clk),
    .rst_n     (rst_n),
    .req       (obuf_req),
    .stat      (obuf_stat),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

  // brace level never leaves its saturation window
  a_depth_range: assert property (@(posedge clk) disable iff (!rst_n)
    (depth_r <= DMAX) && (depth_r >= DMIN))
    else $error("brace depth out of range");

  // indent burst always has spaces left to send
  a_indent_cnt: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_INDENT) |-> (cnt_r != '0))
    else $error("indent state with empty count");

  // a result without a character only closes a text
  a_bare_marker: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_data.has_byte) |->
      (out_data.text_end && out_data.run_last && (out_data.out_byte == 8'h00)))
    else $error("bare result is not a clean end marker");

  // one item at a time: no transfer right after a transfer
  a_busy_after_take: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && in_ready) |=> !in_ready)
    else $error("input taken while an item is in work");

endmodule

### bench/bif_format_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bif_format_checker: result predictor and scoreboard of the brace formatter
// watches both channels, works out the formatted bytes of every input
// transfer and compares each result transfer with the oldest one awaited
// ----------------------------------------------------------------------------
module bif_format_checker (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  input  logic               in_ready,
  input  bif_pkg::in_item_t  in_data,
  input  logic               out_valid,
  input  logic               out_ready,
  input  bif_pkg::out_item_t out_data,
  output int                 fail_count,
  output int                 pending_count
);
  import bif_pkg::*;

  localparam int RUN_CAP = 64;

  // formatter line state
  logic brk_owed;
  logic line_clean;
  logic sp_owed;
  logic last_nl;
  logic at_line_start;
  logic nl_held;
  int   depth;

  logic [7:0] run_chars[$];
  out_item_t  awaited_q[$];

  initial begin
    fail_count    = 0;
    pending_count = 0;
  end

  function automatic void clear_line_state();
    brk_owed      = 1'b0;
    line_clean    = 1'b1;
    sp_owed       = 1'b0;
    last_nl       = 1'b0;
    at_line_start = 1'b1;
    depth         = 0;
    nl_held       = 1'b0;
  endfunction

  function automatic void put_char(logic [7:0] c);
    if (run_chars.size() < RUN_CAP) run_chars.push_back(c);
  endfunction

  // newline is held back until more text follows
  function automatic void hold_out(logic [7:0] c);
    if (c == CH_NL) begin
      nl_held = 1'b1;
    end else begin
      if (nl_held) begin
        put_char(CH_NL);
        nl_held = 1'b0;
      end
      put_char(c);
    end
  endfunction

  function automatic void indent_out(logic [7:0] c);
    int n;
    if (c == CH_CLOS && at_line_start && depth > -MAX_DEPTH) depth--;
    if (at_line_start && c != CH_NL) begin
      for (n = 0; n < depth * 4; n++) hold_out(CH_SP);
      at_line_start = 1'b0;
    end
    hold_out(c);
    if (c == CH_NL) at_line_start = 1'b1;
    if (c == CH_OPEN && depth < MAX_DEPTH) depth++;
  endfunction

  function automatic void drop_blank(logic [7:0] c);
    if (c == CH_NL) begin
      if (!last_nl) begin
        indent_out(c);
        last_nl = 1'b1;
      end
    end else begin
      indent_out(c);
      last_nl = 1'b0;
    end
  endfunction

  function automatic void squeeze_space(logic [7:0] c);
    if (c == CH_NL) begin
      sp_owed    = 1'b0;
      line_clean = 1'b1;
      drop_blank(c);
    end else if (c == CH_SP) begin
      if (!line_clean) sp_owed = 1'b1;
    end else begin
      if (sp_owed) begin
        drop_blank(CH_SP);
        sp_owed = 1'b0;
      end
      drop_blank(c);
      line_clean = 1'b0;
    end
  endfunction

  function automatic void break_after(logic [7:0] c);
    if (brk_owed && c != CH_NL) squeeze_space(CH_NL);
    brk_owed = (c == CH_SEMI || c == CH_OPEN || c == CH_CLOS);
    squeeze_space(c);
  endfunction

  function automatic void predict_format(in_item_t it);
    out_item_t r;
    int k;
    run_chars.delete();
    break_after(it.in_byte);
    if (it.in_last && it.in_byte != CH_NL) break_after(CH_NL);
    if (it.in_last && run_chars.size() == 0) begin
      r = '{out_byte: 8'h00, has_byte: 1'b0, run_last: 1'b1, text_end: 1'b1};
      awaited_q.push_back(r);
    end else begin
      for (k = 0; k < run_chars.size(); k++) begin
        r.out_byte = run_chars[k];
        r.has_byte = 1'b1;
        r.run_last = (k == run_chars.size() - 1);
        r.text_end = (k == run_chars.size() - 1) && it.in_last;
        awaited_q.push_back(r);
      end
    end
    if (it.in_last) clear_line_state();
  endfunction

  task automatic report(string what, logic [7:0] want, logic [7:0] got);
    $display("mismatch %s: expected %02h got %02h", what, want, got);
    fail_count++;
  endtask

  always @(posedge clk) begin
    out_item_t want;
    if (!rst_n) begin
      clear_line_state();
      awaited_q.delete();
    end else begin
      if (in_valid && in_ready) predict_format(in_data);
      if (out_valid && out_ready) begin
        if (awaited_q.size() == 0) begin
          report("unexpected result", 8'h00, out_data.out_byte);
        end else begin
          want = awaited_q.pop_front();
          if (out_data.out_byte !== want.out_byte)
            report("out_byte", want.out_byte, out_data.out_byte);
          if (out_data.has_byte !== want.has_byte)
            report("has_byte", 8'(want.has_byte), 8'(out_data.has_byte));
          if (out_data.run_last !== want.run_last)
            report("run_last", 8'(want.run_last), 8'(out_data.run_last));
          if (out_data.text_end !== want.text_end)
            report("text_end", 8'(want.text_end), 8'(out_data.text_end));
        end
      end
    end
    pending_count = awaited_q.size();
  end

endmodule

### bench/tb_brace_indent_text_formatter_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_brace_indent_text_formatter_core: stimulus and verdict of the formatter
// sends directed snippets and then random code-like, brace-heavy and noise
// texts with random gaps and stalls; the checker beside the block scores it
// ----------------------------------------------------------------------------
module tb_brace_indent_text_formatter_core;
  import bif_pkg::*;

  localparam int ITEM_TARGET = 350;
  localparam int CYCLE_LIMIT = 200000;
  localparam int HOLD_CYCLES = 400;
  localparam int HOLD_AT     = 220;
  localparam int DRAIN_AT    = 290;
  localparam int TAIL_CYCLES = 40;

  logic      clk       = 1'b0;
  logic      rst_n     = 1'b0;
  logic      in_valid  = 1'b0;
  logic      in_ready;
  in_item_t  in_data   = '0;
  logic      out_valid;
  logic      out_ready = 1'b0;
  out_item_t out_data;

  logic in_fire  = 1'b0;
  logic hold_off = 1'b0;
  logic calm     = 1'b0;
  int   sent_items = 0;
  int   cycle_count = 0;
  int   fail_count;
  int   pending_count;

  brace_indent_text_formatter_core dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

  bif_format_checker u_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_valid      (in_valid),
    .in_ready      (in_ready),
    .in_data       (in_data),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .out_data      (out_data),
    .fail_count    (fail_count),
    .pending_count (pending_count)
  );

  // 10 ns clock
  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // flop the input transfer so the driver can look at it on the falling edge
  always @(posedge clk) begin
    in_fire <= in_valid && in_ready;
  end

  // receiver: random stalls, none in the calm stretch, stalled throughout while held off
  always @(negedge clk) begin
    if (hold_off) begin
      out_ready <= 1'b0;
    end else if (calm) begin
      out_ready <= 1'b1;
    end else begin
      out_ready <= ($urandom_range(99) >= 14);
    end
  end

  // long receiver hold-off, counted in its own process, so the block backs up
  initial begin
    int n;
    wait (sent_items >= HOLD_AT);
    @(posedge clk);
    hold_off = 1'b1;
    for (n = 0; n < HOLD_CYCLES; n++) @(posedge clk);
    hold_off = 1'b0;
  end

  // run limit: a hang or a lost result ends here
  initial begin
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("status: fail");
    $finish;
  end

  // one input transfer; entered and left on a falling edge
  task automatic send(logic [7:0] b, logic last);
    while (!calm && $urandom_range(99) < 14) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= '{in_byte: b, in_last: last};
    do @(negedge clk); while (!in_fire);
    sent_items++;
    // no gaps on either side for a while in the middle of the run
    calm = (sent_items >= 120 && sent_items < 180);
  endtask

  // a whole text, last flag on its final character
  task automatic send_text(string s);
    int i;
    for (i = 0; i < s.len(); i++) send(s[i], i == s.len() - 1);
  endtask

  // sender pause until every awaited result has come out
  task automatic wait_drained();
    in_valid <= 1'b0;
    do @(negedge clk); while (pending_count != 0);
  endtask

  // code-like character mix
  function automatic logic [7:0] code_char();
    int p;
    p = $urandom_range(99);
    if (p < 30) return 8'(8'h61 + $urandom_range(25));
    else if (p < 50) return CH_SP;
    else if (p < 60) return CH_NL;
    else if (p < 68) return CH_SEMI;
    else if (p < 76) return CH_OPEN;
    else if (p < 84) return CH_CLOS;
    else if (p < 88) return 8'h09;
    else if (p < 91) return 8'h0d;
    else return 8'($urandom_range(255));
  endfunction

  initial begin
    int mode;
    int len;
    int i;
    logic up;
    logic drained_once;
    logic [7:0] ch;
    drained_once = 1'b0;

    // reset held low at the start, then released
    repeat (10) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // lone newline as a whole text: nothing to show, bare end marker
    send_text("\n");
    // leading newline kept, leading space dropped, space run squeezed,
    // break after ';', closing brace at line start lowers the level
    send_text("\n {a  b;}\n");
    // empty and blank lines removed, no extra break before a real newline
    send_text("a;\n\n  \nb");
    // negative depth gives no indent, final newline implied
    send_text("}}x");
    // byte extremes, tab and carriage return as ordinary text,
    // trailing space on the final character
    send(8'h00, 1'b0);
    send(8'hff, 1'b0);
    send_text("\t\015 ");

    // random texts
    while (sent_items < ITEM_TARGET) begin
      mode = $urandom_range(99);
      if (mode < 70) begin
        len = $urandom_range(24, 1);
        for (i = 0; i < len; i++) send(code_char(), i == len - 1);
      end else if (mode < 85) begin
        // brace storm, deep enough to reach the depth limits
        up  = 1'($urandom_range(1));
        len = $urandom_range(40, 24);
        for (i = 0; i < len; i++) begin
          if ($urandom_range(99) < 60) ch = up ? CH_OPEN : CH_CLOS;
          else ch = code_char();
          send(ch, i == len - 1);
        end
      end else begin
        // noise: any byte, short texts
        len = $urandom_range(8, 1);
        for (i = 0; i < len; i++) send(8'($urandom_range(255)), i == len - 1);
      end
      if (!drained_once && sent_items >= DRAIN_AT) begin
        drained_once = 1'b1;
        wait_drained();
      end
    end

    in_valid <= 1'b0;
    while (pending_count != 0) @(negedge clk);
    repeat (TAIL_CYCLES) @(negedge clk);

    if (fail_count == 0 && pending_count == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule
